// ===== rtl/rbf_svm_classifier_macros.svh =====
// Assertion helpers shared by the block.
`ifndef RBF_SVM_CLASSIFIER_MACROS_SVH
`define RBF_SVM_CLASSIFIER_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define RSVM_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("rsvm same-cycle check failed");

// Next-cycle implication, ignored during reset.
`define RSVM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("rsvm next-cycle check failed");

`endif

// ===== rtl/rsvm_pkg.sv =====
package rsvm_pkg;

  localparam logic [1:0] OP_WRITE_VECTOR = 2'd0;
  localparam logic [1:0] OP_WRITE_COEF   = 2'd1;
  localparam logic [1:0] OP_QUERY        = 2'd2;

  localparam logic [1:0] REG_GAMMA          = 2'd0;
  localparam logic [1:0] REG_BIAS           = 2'd1;
  localparam logic [1:0] REG_ACTIVE_VECTORS = 2'd2;
  localparam logic [1:0] REG_FEATURE_COUNT  = 2'd3;

  localparam int ACC_W = 56;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         vector_index;
    logic [3:0]         feature_index;
    logic signed [15:0] feature_value;
    logic signed [23:0] coefficient;
    logic               last_feature;
  } in_t;

  typedef struct packed {
    logic               class_positive;
    logic signed [31:0] margin;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic f_last;
    logic v_last;
    logic nv_zero;
    logic busy;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/rsvm_ram.sv =====
module rsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/rsvm_ctrl.sv =====
module rsvm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsvm_pkg::in_t    in_data,
  input  rsvm_pkg::status_t status,
  output rsvm_pkg::cmd_t   cmd
);
  import rsvm_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state, state_next;
  logic       fire, go;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;
  assign go       = fire && (in_data.operation == OP_QUERY) && in_data.last_feature;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = fire;
    case (state)
      S_IDLE: begin
        if (go) begin
          cmd.start  = 1'b1;
          state_next = status.nv_zero ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (status.f_last && status.v_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold the sum until the result register frees up
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/rsvm_datapath.sv =====
module rsvm_datapath #(
  parameter int MAX_VECTORS     = 256,
  parameter int MAX_FEATURES    = 16,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  rsvm_pkg::in_t     in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  rsvm_pkg::cmd_t    cmd,
  output rsvm_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output rsvm_pkg::out_t    out_data
);
  import rsvm_pkg::*;

  localparam int VDEPTH = MAX_VECTORS * MAX_FEATURES;
  localparam int VAW    = VDEPTH > 1 ? $clog2(VDEPTH) : 1;
  localparam int CAW    = MAX_VECTORS > 1 ? $clog2(MAX_VECTORS) : 1;
  localparam int QAW    = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int FCW    = $clog2(MAX_FEATURES + 1);
  localparam int VCW    = $clog2(MAX_VECTORS + 1);
  localparam int EAW    = $clog2(EXP_TABLE_DEPTH);
  localparam int DW     = 33 + $clog2(MAX_FEATURES + 1);
  localparam int AW     = DW + 16;
  localparam int HW     = AW - 18;

  typedef logic [15:0] rom_t [EXP_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] v;
    logic [63:0] e;
    v = 64'd1 << 31;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      e    = (v + 64'd16384) >> 15;
      r[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      v    = (v * 64'd2114190000 + (64'd1 << 30)) >> 31;
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  // configuration
  logic [15:0]        gamma;
  logic signed [31:0] bias;
  logic [8:0]         active_vectors;
  logic [4:0]         feature_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma          <= 16'd32768;
      bias           <= '0;
      active_vectors <= '0;
      feature_count  <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA:          gamma          <= cfg_data[15:0];
        REG_BIAS:           bias           <= cfg_data;
        REG_ACTIVE_VECTORS: active_vectors <= cfg_data[8:0];
        REG_FEATURE_COUNT:  feature_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [FCW-1:0] nf, nf_eff;
  logic [VCW-1:0] nv;
  logic           nf_zero;

  assign nf      = (32'(feature_count) > MAX_FEATURES) ? FCW'(MAX_FEATURES)
                                                       : FCW'(feature_count);
  assign nv      = (32'(active_vectors) > MAX_VECTORS) ? VCW'(MAX_VECTORS)
                                                       : VCW'(active_vectors);
  assign nf_zero = (nf == '0);
  assign nf_eff  = nf_zero ? FCW'(1) : nf;

  // store writes
  logic          vec_we, coef_we, q_we;
  logic [31:0]   vec_wa;

  assign vec_wa  = 32'(in_data.vector_index) * MAX_FEATURES + 32'(in_data.feature_index);
  assign vec_we  = cmd.accept && (in_data.operation == OP_WRITE_VECTOR)
                   && (32'(in_data.vector_index) < MAX_VECTORS)
                   && (32'(in_data.feature_index) < MAX_FEATURES);
  assign coef_we = cmd.accept && (in_data.operation == OP_WRITE_COEF)
                   && (32'(in_data.vector_index) < MAX_VECTORS);
  assign q_we    = cmd.accept && (in_data.operation == OP_QUERY)
                   && (32'(in_data.feature_index) < MAX_FEATURES);

  // walk counters
  logic [FCW-1:0] f;
  logic [VCW-1:0] v;
  logic [VAW:0]   base;
  logic [VAW:0]   vec_ra_full;

  assign status.f_last  = (f == nf_eff - FCW'(1));
  assign status.v_last  = (v == nv - VCW'(1));
  assign status.nv_zero = (nv == '0);
  assign vec_ra_full    = base + (VAW + 1)'(f);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      f    <= '0;
      v    <= '0;
      base <= '0;
    end else if (cmd.issue) begin
      if (status.f_last) begin
        f    <= '0;
        v    <= v + VCW'(1);
        base <= base + (VAW + 1)'(MAX_FEATURES);
      end else begin
        f <= f + FCW'(1);
      end
    end
  end

  logic [15:0] vec_rd, q_rd;
  logic [23:0] coef_rd;

  rsvm_ram #(.WIDTH(16), .DEPTH(VDEPTH)) u_vec_ram (
    .clk     (clk),
    .we      (vec_we),
    .wr_addr (vec_wa[VAW-1:0]),
    .wr_data (in_data.feature_value),
    .rd_addr (vec_ra_full[VAW-1:0]),
    .rd_data (vec_rd)
  );

  rsvm_ram #(.WIDTH(24), .DEPTH(MAX_VECTORS)) u_coef_ram (
    .clk     (clk),
    .we      (coef_we),
    .wr_addr (CAW'(in_data.vector_index)),
    .wr_data (in_data.coefficient),
    .rd_addr (CAW'(v)),
    .rd_data (coef_rd)
  );

  rsvm_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_q_ram (
    .clk     (clk),
    .we      (q_we),
    .wr_addr (QAW'(in_data.feature_index)),
    .wr_data (in_data.feature_value),
    .rd_addr (QAW'(f)),
    .rd_data (q_rd)
  );

  // pipeline tags: valid and end-of-vector
  logic [7:1] pv;
  logic [3:1] pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
      pl <= '0;
    end else begin
      pv[1] <= cmd.issue;
      pl[1] <= status.f_last;
      pv[2] <= pv[1];
      pl[2] <= pl[1];
      pv[3] <= pv[2];
      pl[3] <= pl[2];
      pv[4] <= pv[3] && pl[3];
      pv[5] <= pv[4];
      pv[6] <= pv[5];
      pv[7] <= pv[6];
    end
  end

  assign status.busy = |pv;

  logic signed [16:0]  diff;
  logic [32:0]         sq;
  logic signed [33:0]  sq_full;
  logic [DW-1:0]       dist_acc, dist_sum, dist_fin;
  logic [AW-1:0]       arg;
  logic [HW-1:0]       arg_hi;
  logic [16:0]         k;
  logic signed [23:0]  coef2, coef3, coef4, coef5, coef6;
  logic signed [41:0]  prod;
  logic signed [ACC_W-1:0] acc;

  assign sq_full  = diff * diff;
  assign dist_sum = dist_acc + DW'(sq);
  assign arg_hi   = arg[AW-1:18];

  always_ff @(posedge clk) begin
    diff  <= nf_zero ? 17'sd0 : (17'(signed'(q_rd)) - 17'(signed'(vec_rd)));
    coef2 <= coef_rd;
    sq    <= sq_full[32:0];
    coef3 <= coef2;
    if (cmd.start) begin
      dist_acc <= '0;
    end else if (pv[3]) begin
      dist_acc <= pl[3] ? '0 : dist_sum;
    end
    if (pv[3] && pl[3]) begin
      dist_fin <= dist_sum;
      coef4    <= coef3;
    end
    arg   <= dist_fin * AW'(gamma);
    coef5 <= coef4;
    k     <= (arg_hi < HW'(EXP_TABLE_DEPTH)) ? {1'b0, EXP_ROM[arg_hi[EAW-1:0]]} : 17'd0;
    coef6 <= coef5;
    prod  <= coef6 * signed'(k);
    if (cmd.start) begin
      acc <= ACC_W'(bias) <<< 16;
    end else if (pv[7]) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor to Q16.16 and clip
  logic signed [ACC_W-17:0] m_wide;
  logic                     sat;
  logic signed [31:0]       m_clip;

  assign m_wide = (ACC_W - 16)'(acc >>> 16);
  assign sat    = (m_wide[ACC_W-17:31] != '0) && (m_wide[ACC_W-17:31] != '1);
  assign m_clip = !sat ? m_wide[31:0]
                       : (m_wide[ACC_W-17] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.margin         <= m_clip;
      out_data.saturated      <= sat;
      out_data.class_positive <= !m_clip[31] && (m_clip != '0);
    end
  end
endmodule

// ===== rtl/rbf_svm_classifier.sv =====
// RBF-kernel SVM classifier.
// Input channel (in_valid/in_ready/in_data) carries one word per item:
// support-vector feature writes, coefficient writes and query features.
// Store writes are taken whenever the block is idle. A query word with last_feature set
// starts a classification; the block then walks every active vector and
// feature through one multiply-accumulate pipeline, one feature per cycle.
// in_ready stays low from that word until the finished sum is loaded
// into the result register.
// Output channel (out_valid/out_ready/out_data) holds one result register:
// while it waits, loads and queries are still taken; a finished sum waits
// for the register to free before in_ready returns.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used only while idle. Reset clears configuration to defaults and empties
// the pipeline; the stores are not cleared and must be written before use.
module rbf_svm_classifier #(
  parameter int MAX_VECTORS     = 256,
  parameter int MAX_FEATURES    = 16,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsvm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rsvm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import rsvm_pkg::*;
  `include "rbf_svm_classifier_macros.svh"

  cmd_t    cmd;
  status_t status;

  rsvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  rsvm_datapath #(
    .MAX_VECTORS     (MAX_VECTORS),
    .MAX_FEATURES    (MAX_FEATURES),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RSVM_ASSERT_NOW(a_idle_empty, clk, rst, in_ready, !status.busy)
  `RSVM_ASSERT_NOW(a_issue_busy, clk, rst, cmd.issue, !in_ready)
  `RSVM_ASSERT_NEXT(a_load_valid, clk, rst, cmd.load_out, out_valid && in_ready)
endmodule
